FILE: rtl/cau_pkg.sv
// Shared types, codes and saturation helpers of the complex arithmetic unit.
package cau_pkg;

    typedef enum logic [2:0] {
        MODE_NEG = 3'd0,
        MODE_ADD = 3'd1,
        MODE_SUB = 3'd2,
        MODE_MUL = 3'd3,
        MODE_DIV = 3'd4,
        MODE_EQ  = 3'd5
    } mode_t;

    localparam logic [1:0] ST_OK  = 2'd0;
    localparam logic [1:0] ST_SAT = 2'd1;
    localparam logic [1:0] ST_DZ  = 2'd2;

    // Remainder width of the divider row and width of its quotient.
    localparam int DIV_W = 98;
    localparam int Q_W   = 34;

    typedef struct packed {
        logic [31:0] val;
        logic        sat;
    } sat_t;

    typedef struct packed {
        logic [2:0]  mode;
        logic [31:0] rr;
        logic [31:0] ri;
        logic        eq;
        logic [1:0]  st;
        logic        neg_re;
        logic        neg_im;
        logic        den_zero;
    } side_t;

    typedef struct packed {
        logic             valid;
        logic [63:0]      den;
        logic [DIV_W-1:0] r_re;
        logic [DIV_W-1:0] r_im;
        logic [Q_W-1:0]   q_re;
        logic [Q_W-1:0]   q_im;
        side_t            side;
    } stage_t;

    function automatic sat_t sat_mag(input logic neg, input logic [63:0] mag);
        sat_t        r;
        logic [31:0] v;
        if (neg)
        begin
            r.sat = (mag > 64'h0000_0000_8000_0000);
            v     = r.sat ? 32'h8000_0000 : mag[31:0];
            r.val = 32'd0 - v;
        end
        else
        begin
            r.sat = (mag > 64'h0000_0000_7FFF_FFFF);
            r.val = r.sat ? 32'h7FFF_FFFF : mag[31:0];
        end
        return r;
    endfunction

    function automatic sat_t sat33(input logic [32:0] v);
        sat_t r;
        r.sat = v[32] ^ v[31];
        if (r.sat)
        begin
            r.val = v[32] ? 32'h8000_0000 : 32'h7FFF_FFFF;
        end
        else
        begin
            r.val = v[31:0];
        end
        return r;
    endfunction

endpackage

FILE: rtl/cau_div_cell.sv
// One restoring-division cell: decides one quotient bit for both result parts.
module cau_div_cell
    import cau_pkg::*;
#(
    parameter int SHIFT = 0
)
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   en,
    input  stage_t din,
    output stage_t dout
);

    logic [DIV_W-1:0] d;
    logic             ge_re;
    logic             ge_im;
    stage_t           cell_next;
    logic             valid_reg;
    stage_t           data_reg;

    always_comb
    begin
        d         = {{(DIV_W-64){1'b0}}, din.den} << SHIFT;
        ge_re     = (din.r_re >= d);
        ge_im     = (din.r_im >= d);
        cell_next = din;
        cell_next.r_re = ge_re ? din.r_re - d : din.r_re;
        cell_next.r_im = ge_im ? din.r_im - d : din.r_im;
        cell_next.q_re[SHIFT] = ge_re;
        cell_next.q_im[SHIFT] = ge_im;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= din.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            data_reg <= cell_next;
        end
    end

    always_comb
    begin
        dout       = data_reg;
        dout.valid = valid_reg;
    end

endmodule

FILE: rtl/complex_arith_unit.sv
// Top level of the complex arithmetic unit: operand stages, divider row and output register.
// The unit accepts one beat per cycle while the output is not stalled and returns one result
// beat for each, after three operand stages (input register, the six 32 by 32 products,
// the wide sums), a row of 34 division cells that each settle one quotient bit, and
// the output register. Every operation travels the full pipeline, so results leave
// in order. The whole pipeline advances whenever the output register is empty or
// being taken, so a stalled output stops all stages together.
module complex_arith_unit
    import cau_pkg::*;
#(
    parameter int FRAC_BITS = 16
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // a_real, a_imag, b_real, b_imag
    input  logic [127:0] s_axis_tdata,
    // mode
    input  logic [7:0]   s_axis_tuser,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // res_real, res_imag, is_equal, status, zero fill
    output logic [71:0]  m_axis_tdata
);

    logic adv;

    logic               a_valid_reg;
    logic [2:0]         a_mode_reg;
    logic signed [31:0] a_ar_reg, a_ai_reg, a_br_reg, a_bi_reg;

    logic               b_valid_reg;
    logic [2:0]         b_mode_reg;
    logic signed [63:0] b_p_rr_reg, b_p_ii_reg, b_p_ri_reg, b_p_ir_reg;
    logic signed [63:0] b_sq_r_reg, b_sq_i_reg;
    logic [31:0]        b_rr_reg, b_ri_reg;
    logic               b_eq_reg, b_sat_reg;
    logic [31:0]        b_rr_next, b_ri_next;
    logic               b_eq_next, b_sat_next;
    sat_t               s_re, s_im;

    logic               c_valid_reg;
    logic [2:0]         c_mode_reg;
    logic signed [64:0] c_s_re_reg, c_s_im_reg;
    logic [63:0]        c_den_reg;
    logic [31:0]        c_rr_reg, c_ri_reg;
    logic               c_eq_reg, c_sat_reg;

    logic               neg_re, neg_im;
    logic [64:0]        mag_re, mag_im;
    sat_t               m_re, m_im;
    stage_t             chain [0:Q_W];

    stage_t             z;
    sat_t               q_re_s, q_im_s;
    logic [31:0]        res_re, res_im;
    logic               res_eq;
    logic [1:0]         res_st;

    logic               out_valid_reg;
    logic [71:0]        out_data_reg;

    assign adv           = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = adv;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg   <= 1'b0;
            b_valid_reg   <= 1'b0;
            c_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            a_valid_reg   <= s_axis_tvalid;
            b_valid_reg   <= a_valid_reg;
            c_valid_reg   <= b_valid_reg;
            out_valid_reg <= z.valid;
        end
    end

    always_comb
    begin
        b_rr_next  = 32'd0;
        b_ri_next  = 32'd0;
        b_eq_next  = 1'b0;
        s_re       = sat33({a_ar_reg[31], a_ar_reg});
        s_im       = sat33({a_ai_reg[31], a_ai_reg});
        s_re.sat   = 1'b0;
        s_im.sat   = 1'b0;
        unique case (a_mode_reg)
            MODE_NEG:
            begin
                s_re = sat33(33'd0 - {a_ar_reg[31], a_ar_reg});
                s_im = sat33(33'd0 - {a_ai_reg[31], a_ai_reg});
            end
            MODE_ADD:
            begin
                s_re = sat33({a_ar_reg[31], a_ar_reg} + {a_br_reg[31], a_br_reg});
                s_im = sat33({a_ai_reg[31], a_ai_reg} + {a_bi_reg[31], a_bi_reg});
            end
            MODE_SUB:
            begin
                s_re = sat33({a_ar_reg[31], a_ar_reg} - {a_br_reg[31], a_br_reg});
                s_im = sat33({a_ai_reg[31], a_ai_reg} - {a_bi_reg[31], a_bi_reg});
            end
            MODE_EQ:
            begin
                b_eq_next = (a_ar_reg == a_br_reg) && (a_ai_reg == a_bi_reg);
            end
            default:
            begin
                s_re.val = 32'd0;
            end
        endcase
        if (a_mode_reg == MODE_NEG || a_mode_reg == MODE_ADD || a_mode_reg == MODE_SUB)
        begin
            b_rr_next = s_re.val;
            b_ri_next = s_im.val;
        end
        b_sat_next = s_re.sat | s_im.sat;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            a_mode_reg <= s_axis_tuser[2:0];
            a_ar_reg   <= s_axis_tdata[31:0];
            a_ai_reg   <= s_axis_tdata[63:32];
            a_br_reg   <= s_axis_tdata[95:64];
            a_bi_reg   <= s_axis_tdata[127:96];

            b_mode_reg <= a_mode_reg;
            b_p_rr_reg <= a_ar_reg * a_br_reg;
            b_p_ii_reg <= a_ai_reg * a_bi_reg;
            b_p_ri_reg <= a_ar_reg * a_bi_reg;
            b_p_ir_reg <= a_ai_reg * a_br_reg;
            b_sq_r_reg <= a_br_reg * a_br_reg;
            b_sq_i_reg <= a_bi_reg * a_bi_reg;
            b_rr_reg   <= b_rr_next;
            b_ri_reg   <= b_ri_next;
            b_eq_reg   <= b_eq_next;
            b_sat_reg  <= b_sat_next;

            c_mode_reg <= b_mode_reg;
            if (b_mode_reg == MODE_DIV)
            begin
                c_s_re_reg <= {b_p_rr_reg[63], b_p_rr_reg} + {b_p_ii_reg[63], b_p_ii_reg};
                c_s_im_reg <= {b_p_ir_reg[63], b_p_ir_reg} - {b_p_ri_reg[63], b_p_ri_reg};
            end
            else
            begin
                c_s_re_reg <= {b_p_rr_reg[63], b_p_rr_reg} - {b_p_ii_reg[63], b_p_ii_reg};
                c_s_im_reg <= {b_p_ri_reg[63], b_p_ri_reg} + {b_p_ir_reg[63], b_p_ir_reg};
            end
            c_den_reg  <= b_sq_r_reg + b_sq_i_reg;
            c_rr_reg   <= b_rr_reg;
            c_ri_reg   <= b_ri_reg;
            c_eq_reg   <= b_eq_reg;
            c_sat_reg  <= b_sat_reg;
        end
    end

    always_comb
    begin
        neg_re = c_s_re_reg[64];
        neg_im = c_s_im_reg[64];
        mag_re = neg_re ? 65'd0 - c_s_re_reg : c_s_re_reg;
        mag_im = neg_im ? 65'd0 - c_s_im_reg : c_s_im_reg;
        m_re   = sat_mag(neg_re, mag_re[63:0] >> FRAC_BITS);
        m_im   = sat_mag(neg_im, mag_im[63:0] >> FRAC_BITS);

        chain[0].valid         = c_valid_reg;
        chain[0].den           = c_den_reg;
        chain[0].r_re          = {{(DIV_W-64){1'b0}}, mag_re[63:0]} << FRAC_BITS;
        chain[0].r_im          = {{(DIV_W-64){1'b0}}, mag_im[63:0]} << FRAC_BITS;
        chain[0].q_re          = '0;
        chain[0].q_im          = '0;
        chain[0].side.mode     = c_mode_reg;
        chain[0].side.eq       = c_eq_reg;
        chain[0].side.neg_re   = neg_re;
        chain[0].side.neg_im   = neg_im;
        chain[0].side.den_zero = (c_den_reg == 64'd0);
        if (c_mode_reg == MODE_MUL)
        begin
            chain[0].side.rr = m_re.val;
            chain[0].side.ri = m_im.val;
            chain[0].side.st = (m_re.sat | m_im.sat) ? ST_SAT : ST_OK;
        end
        else
        begin
            chain[0].side.rr = c_rr_reg;
            chain[0].side.ri = c_ri_reg;
            chain[0].side.st = c_sat_reg ? ST_SAT : ST_OK;
        end
    end

    genvar gi;
    generate
        for (gi = 0; gi < Q_W; gi++)
        begin : g_div
            cau_div_cell #(
                .SHIFT(Q_W - 1 - gi)
            ) u_cell (
                .clk  (clk),
                .rst_n(rst_n),
                .en   (adv),
                .din  (chain[gi]),
                .dout (chain[gi+1])
            );
        end
    endgenerate

    always_comb
    begin
        z      = chain[Q_W];
        q_re_s = sat_mag(z.side.neg_re, {{(64-Q_W){1'b0}}, z.q_re});
        q_im_s = sat_mag(z.side.neg_im, {{(64-Q_W){1'b0}}, z.q_im});
        res_re = z.side.rr;
        res_im = z.side.ri;
        res_eq = z.side.eq;
        res_st = z.side.st;
        if (z.side.mode == MODE_DIV)
        begin
            if (z.side.den_zero)
            begin
                res_re = 32'd0;
                res_im = 32'd0;
                res_st = ST_DZ;
            end
            else
            begin
                res_re = q_re_s.val;
                res_im = q_im_s.val;
                res_st = (q_re_s.sat | q_im_s.sat) ? ST_SAT : ST_OK;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            out_data_reg <= {5'd0, res_st, res_eq, res_im, res_re};
        end
    end

    a_accept_fills: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> a_valid_reg)
        else $error("accepted beat did not enter the input stage");

    a_dz_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tdata[66:65] == ST_DZ |-> m_axis_tdata[63:0] == 64'd0)
        else $error("division by zero result is not zero");

    a_eq_clean: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tdata[64] |->
            m_axis_tdata[63:0] == 64'd0 && m_axis_tdata[66:65] == ST_OK)
        else $error("equality result carries data or status");

    a_st_code: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata[66:65] != 2'd3 && m_axis_tdata[71:67] == 5'd0)
        else $error("result beat has an invalid status or fill");

endmodule
